// ===== rtl/tpd_pkg.sv =====
// Shared constants and types for the touch packet decoder.
// No dependencies; used by tpd_pkt_asm, tpd_scale and touch_packet_decoder.
`default_nettype none

package tpd_pkg;

    localparam int BYTE_BITS    = 8;
    localparam int PAYLOAD_BITS = 7;
    localparam int COORD_BITS   = 2 * PAYLOAD_BITS;
    localparam int SIZE_BITS    = 11;
    localparam int RAW_BITS_DEF = 12;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 11'd800;
    localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 11'd480;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 2'd1;

    // Control that travels with an assembled packet
    typedef struct packed {
        logic valid;
        logic pen_down;
    } t_pkt_ctl;

endpackage

`default_nettype wire

// ===== rtl/tpd_pkt_asm.sv =====
// Packet assembler: tracks the five-byte packet framing and registers the joined,
// clamped raw coordinates. Depends on tpd_pkg.
`default_nettype none

module tpd_pkt_asm #(
    parameter int RAW_BITS = tpd_pkg::RAW_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_accept,
    input  wire logic                           i_advance,
    input  wire logic [tpd_pkg::BYTE_BITS-1:0]  i_rx_byte,
    output tpd_pkg::t_pkt_ctl                   o_ctl,
    output logic      [RAW_BITS-1:0]            o_raw_x,
    output logic      [RAW_BITS-1:0]            o_raw_y
);

    localparam int PB = tpd_pkg::PAYLOAD_BITS;
    localparam int CB = tpd_pkg::COORD_BITS;
    localparam logic [CB-1:0] RawMax = CB'((32'd1 << RAW_BITS) - 32'd1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_X_LO,
        PH_X_HI,
        PH_Y_LO,
        PH_Y_HI
    } t_phase;

    t_phase          r_phase, n_phase;
    logic            r_pen, n_pen;
    logic [PB-1:0]   r_x_lo, n_x_lo;
    logic [PB-1:0]   r_x_hi, n_x_hi;
    logic [PB-1:0]   r_y_lo, n_y_lo;
    logic            r_valid, n_valid;
    logic [RAW_BITS-1:0] r_raw_x, n_raw_x;
    logic [RAW_BITS-1:0] r_raw_y, n_raw_y;

    logic            w_status;
    logic [PB-1:0]   w_payload;
    logic [CB-1:0]   w_join_x, w_join_y;

    assign w_status  = i_rx_byte[tpd_pkg::BYTE_BITS-1];
    assign w_payload = i_rx_byte[PB-1:0];
    assign w_join_x  = {r_x_hi, r_x_lo};
    assign w_join_y  = {w_payload, r_y_lo};

    always_comb begin
        n_phase = r_phase;
        n_pen   = r_pen;
        n_x_lo  = r_x_lo;
        n_x_hi  = r_x_hi;
        n_y_lo  = r_y_lo;
        n_valid = 1'b0;
        n_raw_x = (w_join_x > RawMax) ? RawMax[RAW_BITS-1:0] : w_join_x[RAW_BITS-1:0];
        n_raw_y = (w_join_y > RawMax) ? RawMax[RAW_BITS-1:0] : w_join_y[RAW_BITS-1:0];
        if (w_status) begin
            // resync: any partial packet is dropped
            n_pen   = i_rx_byte[0];
            n_phase = PH_X_LO;
        end else begin
            unique case (r_phase)
                PH_X_LO: begin
                    n_x_lo  = w_payload;
                    n_phase = PH_X_HI;
                end
                PH_X_HI: begin
                    n_x_hi  = w_payload;
                    n_phase = PH_Y_LO;
                end
                PH_Y_LO: begin
                    n_y_lo  = w_payload;
                    n_phase = PH_Y_HI;
                end
                PH_Y_HI: begin
                    n_valid = 1'b1;
                    n_phase = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pen   <= 1'b0;
            r_x_lo  <= '0;
            r_x_hi  <= '0;
            r_y_lo  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_phase <= n_phase;
                r_pen   <= n_pen;
                r_x_lo  <= n_x_lo;
                r_x_hi  <= n_x_hi;
                r_y_lo  <= n_y_lo;
            end
            if (i_advance) begin
                r_valid <= i_accept && n_valid;
                r_raw_x <= n_raw_x;
                r_raw_y <= n_raw_y;
            end
        end
    end

    assign o_ctl.valid    = r_valid;
    assign o_ctl.pen_down = r_pen;
    assign o_raw_x        = r_raw_x;
    assign o_raw_y        = r_raw_y;

endmodule

`default_nettype wire

// ===== rtl/tpd_scale.sv =====
// Screen scaling stage and output register: raw * size >> RAW_BITS per axis.
// Depends on tpd_pkg.
`default_nettype none

module tpd_scale #(
    parameter int RAW_BITS = tpd_pkg::RAW_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire tpd_pkg::t_pkt_ctl              i_ctl,
    input  wire logic [RAW_BITS-1:0]            i_raw_x,
    input  wire logic [RAW_BITS-1:0]            i_raw_y,
    input  wire logic [tpd_pkg::SIZE_BITS-1:0]  i_width,
    input  wire logic [tpd_pkg::SIZE_BITS-1:0]  i_height,
    input  wire logic                           i_stall,
    output logic                                o_advance,
    output logic                                o_valid,
    output logic                                o_pen_down,
    output logic      [RAW_BITS-1:0]            o_raw_x,
    output logic      [RAW_BITS-1:0]            o_raw_y,
    output logic      [tpd_pkg::SIZE_BITS-1:0]  o_screen_x,
    output logic      [tpd_pkg::SIZE_BITS-1:0]  o_screen_y
);

    localparam int SB = tpd_pkg::SIZE_BITS;
    localparam int PW = RAW_BITS + SB;

    logic          r_valid;
    logic          r_pen;
    logic [RAW_BITS-1:0] r_raw_x, r_raw_y;
    logic [SB-1:0] r_scr_x, r_scr_y;
    logic [PW-1:0] w_prod_x, w_prod_y;

    assign o_advance = !r_valid || !i_stall;
    assign w_prod_x  = PW'(i_raw_x) * PW'(i_width);
    assign w_prod_y  = PW'(i_raw_y) * PW'(i_height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_ctl.valid;
            r_pen   <= i_ctl.pen_down;
            r_raw_x <= i_raw_x;
            r_raw_y <= i_raw_y;
            r_scr_x <= w_prod_x[RAW_BITS +: SB];
            r_scr_y <= w_prod_y[RAW_BITS +: SB];
        end
    end

    assign o_valid    = r_valid;
    assign o_pen_down = r_pen;
    assign o_raw_x    = r_raw_x;
    assign o_raw_y    = r_raw_y;
    assign o_screen_x = r_scr_x;
    assign o_screen_y = r_scr_y;

endmodule

`default_nettype wire

// ===== rtl/touch_packet_decoder.sv =====
// Top level of the touch packet decoder: configuration registers, packet
// assembler and scaling stage. Depends on tpd_pkg, tpd_pkt_asm and tpd_scale.
`default_nettype none

// Decodes the byte stream of a resistive touch controller. A byte with bit 7
// set is a status byte: it opens a packet (dropping any partial one) and its
// bit 0 is the pen state. Four data bytes follow with 7-bit payloads: X low,
// X high, Y low, Y high; data bytes outside a packet are dropped silently.
// After the fourth data byte one item leaves on the output channel: pen
// state, raw X/Y clamped to 2^RAW_BITS-1, and screen X/Y as
// floor(raw * size / 2^RAW_BITS). One byte is taken every clock unless the
// input is stalled. The assembly register loads at the edge that takes the
// last byte; its packet moves into the multiply-and-output register as soon
// as that register is empty or its item is taken. The input only stalls
// when both stages hold an item and the output is stalled. Screen width and
// height live at register indexes 0 and 1 (reset 800 and 480); write them
// only while no packet result is outstanding. A size of zero gives a screen
// coordinate of 0.
module touch_packet_decoder #(
    parameter int RAW_BITS = tpd_pkg::RAW_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // byte input channel
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [tpd_pkg::BYTE_BITS-1:0]     i_rx_byte,
    // result channel
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic                                   o_pen_down,
    output logic      [RAW_BITS-1:0]               o_raw_x,
    output logic      [RAW_BITS-1:0]               o_raw_y,
    output logic      [tpd_pkg::SIZE_BITS-1:0]     o_screen_x,
    output logic      [tpd_pkg::SIZE_BITS-1:0]     o_screen_y,
    // configuration writes
    input  wire logic                              i_cfg_we,
    input  wire logic [tpd_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [tpd_pkg::SIZE_BITS-1:0]     i_cfg_data
);

    logic [tpd_pkg::SIZE_BITS-1:0] r_width;
    logic [tpd_pkg::SIZE_BITS-1:0] r_height;

    tpd_pkg::t_pkt_ctl   w_pkt;
    logic [RAW_BITS-1:0] w_raw_x, w_raw_y;
    logic                w_out_adv;
    logic                w_asm_adv;
    logic                w_accept;

    // Config registers; out-of-range indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= tpd_pkg::WIDTH_RESET;
            r_height <= tpd_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tpd_pkg::CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                tpd_pkg::CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Assembly register moves when it is empty or the output stage takes it
    assign w_asm_adv = !w_pkt.valid || w_out_adv;
    assign o_stall   = !w_asm_adv;
    assign w_accept  = i_valid && w_asm_adv;

    tpd_pkt_asm #(
        .RAW_BITS (RAW_BITS)
    ) u_asm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_advance (w_asm_adv),
        .i_rx_byte (i_rx_byte),
        .o_ctl     (w_pkt),
        .o_raw_x   (w_raw_x),
        .o_raw_y   (w_raw_y)
    );

    tpd_scale #(
        .RAW_BITS (RAW_BITS)
    ) u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_pkt),
        .i_raw_x    (w_raw_x),
        .i_raw_y    (w_raw_y),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_stall    (i_stall),
        .o_advance  (w_out_adv),
        .o_valid    (o_valid),
        .o_pen_down (o_pen_down),
        .o_raw_x    (o_raw_x),
        .o_raw_y    (o_raw_y),
        .o_screen_x (o_screen_x),
        .o_screen_y (o_screen_y)
    );

    // Input only backs up when both stages are full and the output is held
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall && w_pkt.valid))
        else $error("input stalled while pipeline has room");

    // A status byte never completes a packet
    a_status_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_rx_byte[tpd_pkg::BYTE_BITS-1]) |=> !w_pkt.valid)
        else $error("status byte produced a packet");

    // Nothing comes out straight after reset
    a_clean_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> (!o_valid && !w_pkt.valid))
        else $error("result valid after reset");

endmodule

`default_nettype wire
